/* rtl/core/cas_pkg.sv */
`timescale 1ns / 1ps

package cas_pkg;

    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [8:0]  WIDTH_RESET     = 9'd80;
    localparam logic [12:0] HEIGHT_RESET    = 13'd40;
    localparam logic [3:0]  THRESHOLD_RESET = 4'd5;

    typedef enum logic [1:0] {
        REG_GRID_WIDTH     = 2'd0,
        REG_GRID_HEIGHT    = 2'd1,
        REG_WALL_THRESHOLD = 2'd2
    } cas_reg_t;

    // Geometry and rule settings handed from the register block to the window stage.
    typedef struct packed {
        logic [11:0] last_row;
        logic [3:0]  thr;
        logic        clear;
    } cas_geom_t;

    typedef struct packed {
        logic [7:0]  x;
        logic [11:0] y;
        logic        wall;
    } cas_res_t;

    // Up to three results of one input word, packed from entry 0 upwards.
    typedef struct packed {
        logic [1:0]       count;
        cas_res_t [2:0]   res;
    } cas_set_t;

endpackage

/* rtl/core/cave_automaton_smoothing_pass.sv */
`timescale 1ns / 1ps
// An accepted word is registered in the window stage, and its results in the emitter.
// One word per cycle while m_tready is high; a word with two or three results holds the
// input until its last result leaves, as the output port carries one result word per cycle.
// Reset: counters, window and registers return to their defaults; the line buffer is
// not cleared and needs no clearing pass.

module cave_automaton_smoothing_pass #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [0] cell_wall
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [23:0]                m_tdata,   // [7:0] out_x, [19:8] out_y, [20] out_wall
    output logic                       m_tlast,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cas_pkg::ADDR_W-1:0] paddr,
    input  logic [cas_pkg::DATA_W-1:0] pwdata,
    output logic [cas_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [COL_W-1:0]   last_col;
    cas_pkg::cas_geom_t geom;
    logic               in_accept;
    logic               advance;
    logic               load;
    logic               free;
    logic               s1_valid;
    cas_pkg::cas_set_t  set;
    logic [COL_W-1:0]   rd_addr;
    logic [COL_W-1:0]   wr_addr;
    logic [1:0]         rd_data;
    logic [1:0]         wr_data;

    // A word with no results leaves the window stage whatever the output side does.
    assign advance   = s1_valid && (set.count == 2'd0 || free);
    assign load      = advance && (set.count != 2'd0);
    assign s_tready  = !s1_valid || advance;
    assign in_accept = s_tvalid && s_tready;

    cas_regs #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .last_col (last_col),
        .geom     (geom)
    );

    cas_line_buffer #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_line_buffer (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (advance),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    cas_window #(
        .COL_W (COL_W)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_bit    (s_tdata[0]),
        .advance   (advance),
        .last_col  (last_col),
        .geom      (geom),
        .rd_data   (rd_data),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .s1_valid  (s1_valid),
        .set       (set)
    );

    cas_emitter u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .set_in   (set),
        .free     (free),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/core/cas_line_buffer.sv */
`timescale 1ns / 1ps

module cas_line_buffer #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [1:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [1:0]    wr_data
);

    // Bit 0 holds the row two above the current one, bit 1 the row just above.
    logic [1:0] mem [DEPTH];
    logic [1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

    // Columns of consecutive words differ, so a read never meets a write to its entry.
    a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("line buffer read and write hit the same column");

endmodule

/* rtl/core/cas_regs.sv */
`timescale 1ns / 1ps

module cas_regs #(
    parameter int MAX_WIDTH = 256,
    parameter int COL_W     = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cas_pkg::ADDR_W-1:0] paddr,
    input  logic [cas_pkg::DATA_W-1:0] pwdata,
    output logic [cas_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output logic [COL_W-1:0]           last_col,
    output cas_pkg::cas_geom_t         geom
);

    logic [8:0]        grid_width_reg;
    logic [8:0]        grid_width_next;
    logic [12:0]       grid_height_reg;
    logic [12:0]       grid_height_next;
    logic [3:0]        wall_threshold_reg;
    logic [3:0]        wall_threshold_next;
    logic              clear_reg;
    logic              clear_next;
    logic              wr;
    cas_pkg::cas_reg_t sel;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign sel    = cas_pkg::cas_reg_t'(paddr[3:2]);

    always_comb
    begin
        grid_width_next     = grid_width_reg;
        grid_height_next    = grid_height_reg;
        wall_threshold_next = wall_threshold_reg;
        clear_next          = 1'b0;
        if (wr)
        begin
            unique case (sel)
                cas_pkg::REG_GRID_WIDTH:
                begin
                    grid_width_next = pwdata[8:0];
                    clear_next      = 1'b1;
                end
                cas_pkg::REG_GRID_HEIGHT:
                begin
                    grid_height_next = pwdata[12:0];
                    clear_next       = 1'b1;
                end
                cas_pkg::REG_WALL_THRESHOLD:
                begin
                    wall_threshold_next = pwdata[3:0];
                end
                default:
                begin
                    clear_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg     <= cas_pkg::WIDTH_RESET;
            grid_height_reg    <= cas_pkg::HEIGHT_RESET;
            wall_threshold_reg <= cas_pkg::THRESHOLD_RESET;
            clear_reg          <= 1'b0;
        end
        else
        begin
            grid_width_reg     <= grid_width_next;
            grid_height_reg    <= grid_height_next;
            wall_threshold_reg <= wall_threshold_next;
            clear_reg          <= clear_next;
        end
    end

    always_comb
    begin
        unique case (sel)
            cas_pkg::REG_GRID_WIDTH:     prdata = {23'd0, grid_width_reg};
            cas_pkg::REG_GRID_HEIGHT:    prdata = {19'd0, grid_height_reg};
            cas_pkg::REG_WALL_THRESHOLD: prdata = {28'd0, wall_threshold_reg};
            default:                     prdata = '0;
        endcase
    end

    // Geometry outside the supported range is clamped.
    always_comb
    begin
        if (grid_width_reg < 9'd3)
        begin
            last_col = COL_W'(2);
        end
        else if (32'(grid_width_reg) > MAX_WIDTH)
        begin
            last_col = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = COL_W'(grid_width_reg - 9'd1);
        end

        if (grid_height_reg < 13'd3)
        begin
            geom.last_row = 12'd2;
        end
        else if (grid_height_reg > 13'(cas_pkg::MAX_HEIGHT))
        begin
            geom.last_row = 12'(cas_pkg::MAX_HEIGHT - 1);
        end
        else
        begin
            geom.last_row = 12'(grid_height_reg - 13'd1);
        end

        geom.thr = wall_threshold_reg;

        // The frame restarts on the edge at which a geometry register is written.
        geom.clear = clear_next;
    end

    a_clear_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> $past(wr))
        else $error("frame restart without a geometry write");

endmodule

/* rtl/core/cas_window.sv */
`timescale 1ns / 1ps

module cas_window #(
    parameter int COL_W = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_accept,
    input  logic               in_bit,
    input  logic               advance,
    input  logic [COL_W-1:0]   last_col,
    input  cas_pkg::cas_geom_t geom,
    input  logic [1:0]         rd_data,
    output logic [COL_W-1:0]   rd_addr,
    output logic [COL_W-1:0]   wr_addr,
    output logic [1:0]         wr_data,
    output logic               s1_valid,
    output cas_pkg::cas_set_t  set
);

    logic [COL_W-1:0] col_count_reg;
    logic [COL_W-1:0] col_count_next;
    logic [11:0]      row_count_reg;
    logic [11:0]      row_count_next;
    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [COL_W-1:0] s1_col_reg;
    logic [11:0]      s1_row_reg;
    logic             s1_bit_reg;
    logic [8:0]       win_reg;
    logic [8:0]       win_next;
    logic [8:0]       new_win;
    logic [3:0]       walls;
    logic             smoothed;
    logic [1:0]       n;

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (geom.clear)
        begin
            col_count_next = '0;
            row_count_next = '0;
        end
        else if (in_accept)
        begin
            if (col_count_reg == last_col)
            begin
                col_count_next = '0;
                row_count_next = (row_count_reg == geom.last_row) ? 12'd0
                                                                  : row_count_reg + 12'd1;
            end
            else
            begin
                col_count_next = col_count_reg + COL_W'(1);
            end
        end
    end

    always_comb
    begin
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // Window bit 3*k+j: column k (2 newest), row j (2 current row).
    assign new_win = {s1_bit_reg, rd_data, win_reg[8:3]};

    always_comb
    begin
        if (geom.clear)
        begin
            win_next = '0;
        end
        else if (advance)
        begin
            win_next = new_win;
        end
        else
        begin
            win_next = win_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            win_reg       <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            s1_valid_reg  <= s1_valid_next;
            win_reg       <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_col_reg <= col_count_reg;
            s1_row_reg <= row_count_reg;
            s1_bit_reg <= in_bit;
        end
    end

    assign rd_addr  = col_count_reg;
    assign wr_addr  = s1_col_reg;
    assign wr_data  = {s1_bit_reg, rd_data[1]};
    assign s1_valid = s1_valid_reg;

    assign walls = 4'(new_win[0]) + 4'(new_win[1]) + 4'(new_win[2]) + 4'(new_win[3])
                 + 4'(new_win[5]) + 4'(new_win[6]) + 4'(new_win[7]) + 4'(new_win[8]);

    // Cells in the first row or column pass through; interior cells follow the rule.
    assign smoothed = (s1_col_reg == COL_W'(1) || s1_row_reg == 12'd1) ? new_win[4]
                                                                      : (walls >= geom.thr);

    always_comb
    begin
        set = '0;
        n   = 2'd0;
        if (s1_row_reg != 12'd0 && s1_col_reg != '0)
        begin
            set.res[n].x    = 8'(s1_col_reg - COL_W'(1));
            set.res[n].y    = s1_row_reg - 12'd1;
            set.res[n].wall = smoothed;
            n = n + 2'd1;
        end
        if (s1_row_reg != 12'd0 && s1_col_reg == last_col)
        begin
            set.res[n].x    = 8'(s1_col_reg);
            set.res[n].y    = s1_row_reg - 12'd1;
            set.res[n].wall = new_win[7];
            n = n + 2'd1;
        end
        if (s1_row_reg == geom.last_row)
        begin
            set.res[n].x    = 8'(s1_col_reg);
            set.res[n].y    = s1_row_reg;
            set.res[n].wall = s1_bit_reg;
            n = n + 2'd1;
        end
        set.count = n;
    end

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_count_reg <= last_col)
        else $error("column counter beyond the row width");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_count_reg <= geom.last_row)
        else $error("row counter beyond the frame height");

endmodule

/* rtl/core/cas_emitter.sv */
`timescale 1ns / 1ps

module cas_emitter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  cas_pkg::cas_set_t set_in,
    output logic              free,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [23:0]       m_tdata,
    output logic              m_tlast
);

    logic              valid_reg;
    logic              valid_next;
    logic [1:0]        idx_reg;
    logic [1:0]        idx_next;
    cas_pkg::cas_set_t set_reg;
    cas_pkg::cas_res_t cur;
    logic              last;
    logic              take;

    assign cur  = set_reg.res[idx_reg];
    assign last = (idx_reg == set_reg.count - 2'd1);
    assign take = valid_reg && m_tready;
    assign free = !valid_reg || (take && last);

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
        else if (take)
        begin
            if (last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            set_reg <= set_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'd0, cur.wall, cur.y, cur.x};
    assign m_tlast  = last;

    a_idx_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (idx_reg < set_reg.count))
        else $error("result index beyond the held set");

endmodule
